@@ src/two_group_effect_size_and_t_score_macros.svh @@
// Assertion helpers for the two-group comparison block.
`ifndef TWO_GROUP_EFFECT_SIZE_AND_T_SCORE_MACROS_SVH
`define TWO_GROUP_EFFECT_SIZE_AND_T_SCORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TGES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TGES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/tges_pkg.sv @@
package tges_pkg;

	localparam int CNT_W = 11;
	localparam logic [47:0] VAR_CAP = '1;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic               sample_group;
		logic               is_last;
		logic signed [31:0] mean_a;
		logic signed [31:0] mean_b;
		logic [30:0]        stdev_a;
		logic [30:0]        stdev_b;
		logic [CNT_W-1:0]   count_a;
		logic [CNT_W-1:0]   count_b;
	} in_t;

	typedef struct packed {
		logic signed [31:0] effect_size;
		logic signed [31:0] t_score;
		logic               degenerate;
	} out_t;

	// Request to a serial arithmetic unit; sqrt uses only a.
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} unit_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CM_A,
		ST_CM_B,
		ST_CM_DIV,
		ST_DEV,
		ST_POP_DIV,
		ST_POP_SQRT,
		ST_SA,
		ST_DA,
		ST_SB,
		ST_DB,
		ST_SP,
		ST_VN,
		ST_NN,
		ST_VD,
		ST_TROOT,
		ST_EFF,
		ST_TS,
		ST_OUT
	} state_t;

endpackage

@@ src/tges_mul.sv @@
module tges_mul import tges_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic        busy_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;

	// One multiplier bit per cycle; stop once the remaining bits are zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q == 64'd0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= 64'd0;
		end else if (busy_q && b_q != 64'd0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[62:0], 1'b0};
			b_q <= {1'b0, b_q[63:1]};
		end
	end

	assign rsp.done   = busy_q && b_q == 64'd0;
	assign rsp.result = acc_q;

endmodule

@@ src/tges_div.sv @@
module tges_div import tges_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic        busy_q;
	logic [6:0]  cnt_q;
	logic [63:0] num_q;
	logic [63:0] den_q;
	logic [63:0] rem_q;
	logic [64:0] trial;
	logic        fits;

	// Restoring division, one quotient bit per cycle shifted into num_q.
	assign trial = {rem_q, num_q[63]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			num_q <= req.a;
			den_q <= req.b;
			rem_q <= 64'd0;
		end else if (busy_q && cnt_q != 7'd0) begin
			rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			num_q <= {num_q[62:0], fits};
		end
	end

	assign rsp.done   = busy_q && cnt_q == 7'd0;
	assign rsp.result = num_q;

endmodule

@@ src/tges_sqrt.sv @@
module tges_sqrt import tges_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] cur;
	logic [35:0] trial;
	logic        fits;

	// Two radicand bits per cycle, one root bit per cycle.
	assign cur   = {rem_q, x_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = cur >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (req.start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			x_q    <= req.a;
			rem_q  <= 34'd0;
			root_q <= 32'd0;
		end else if (busy_q && cnt_q != 6'd0) begin
			rem_q  <= fits ? 34'(cur - trial) : cur[33:0];
			root_q <= {root_q[30:0], fits};
			x_q    <= {x_q[61:0], 2'b00};
		end
	end

	assign rsp.done   = busy_q && cnt_q == 6'd0;
	assign rsp.result = {32'd0, root_q};

endmodule

@@ src/two_group_effect_size_and_t_score.sv @@
// Two-group effect size and pooled t-score.
// Input channel: sample / sample_valid / sample_stall. Each transaction is one
// sample plus both group means, deviations and counts. Output channel:
// result / result_valid / result_stall, one transaction per sample marked
// is_last, carrying effect_size, t_score and the degenerate flag.
// All arithmetic runs on three shared serial units: a shift-add multiplier
// (one bit per cycle, stopping once the remaining multiplier bits are zero), a
// restoring divider and a square root.
// A plain sample takes one multiply (the squared deviation, up to 32
// multiplier bits). The first sample of a comparison adds two 11-bit
// multiplies and, unless both counts are zero, one divide. The last sample
// adds, unless the counts are degenerate, the final chain of up to five
// divides, two roots and six multiplies.
// sample_stall is low only while the block waits for a sample.
// A finished result sits in the output register; a new sample is taken
// meanwhile, and only the next result waits while result_stall is high.
// Reset clears the running sum and mean and arms the first-sample step.
module two_group_effect_size_and_t_score import tges_pkg::*; #(
	parameter int MAX_SAMPLES = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  in_t  sample,
	output logic result_valid,
	input  logic result_stall,
	output out_t result
);

`include "two_group_effect_size_and_t_score_macros.svh"

	localparam int VW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam logic [16:0] MAX_L = 17'(MAX_SAMPLES);

	state_t state_q, state_nxt;

	in_t                item_q;
	logic               awaiting_q;
	logic [63:0]        dev_q;
	logic signed [32:0] cm_q;
	logic               sgn_q;
	logic [63:0]        t_q;
	logic [63:0]        u_q;
	logic [31:0]        pop_q;
	logic [31:0]        eff_q;
	logic [31:0]        ts_q;
	logic               degen_q;
	logic               launched_q;
	logic               result_valid_q;
	out_t               result_q;

	unit_req_t mul_req, div_req, sqrt_req;
	unit_rsp_t mul_rsp, div_rsp, sqrt_rsp;
	logic        unit_done;
	logic [63:0] unit_res;

	logic [CNT_W-1:0]   na, nb;
	logic [CNT_W:0]     n;
	logic               degen_cnt;
	logic signed [32:0] x_s, ma_s, mb_s;
	logic signed [33:0] dev_d, diff_d;
	logic [31:0]        dev_m;
	logic [32:0]        diff_m;
	logic [31:0]        ma_m, mb_m;
	logic signed [44:0] wsum;
	logic [64:0]        dev_add;
	logic               out_free;

	function automatic logic [32:0] sx(input logic [31:0] v);
		sx = {{(33 - VW){v[VW-1]}}, v[VW-1:0]};
	endfunction

	function automatic logic [CNT_W-1:0] clampc(input logic [CNT_W-1:0] c);
		clampc = ({6'd0, c} > MAX_L) ? MAX_L[CNT_W-1:0] : c;
	endfunction

	function automatic logic [63:0] capsh(input logic [63:0] v);
		logic [47:0] c;
		c = (v > {16'd0, VAR_CAP}) ? VAR_CAP : v[47:0];
		capsh = {c, 16'd0};
	endfunction

	function automatic logic [31:0] sat(input logic neg, input logic [63:0] q);
		logic [63:0] lim;
		logic [63:0] r;
		lim = 64'd1 << (VW - 1);
		if (q >= lim) begin
			r = neg ? (64'd0 - lim) : (lim - 64'd1);
		end else begin
			r = neg ? (64'd0 - q) : q;
		end
		sat = r[31:0];
	endfunction

	tges_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	tges_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	tges_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));

	// Only one unit runs at a time.
	assign unit_done = mul_rsp.done | div_rsp.done | sqrt_rsp.done;
	assign unit_res  = mul_rsp.done ? mul_rsp.result :
	                   div_rsp.done ? div_rsp.result : sqrt_rsp.result;

	assign na        = clampc(item_q.count_a);
	assign nb        = clampc(item_q.count_b);
	assign n         = {1'b0, na} + {1'b0, nb};
	assign degen_cnt = na == '0 || nb == '0 || n == (CNT_W+1)'(2);

	assign x_s    = sx(item_q.sample_value);
	assign ma_s   = sx(item_q.mean_a);
	assign mb_s   = sx(item_q.mean_b);
	assign ma_m   = ma_s[32] ? 32'(-ma_s) : ma_s[31:0];
	assign mb_m   = mb_s[32] ? 32'(-mb_s) : mb_s[31:0];
	assign dev_d  = 34'(x_s) - 34'(cm_q);
	assign dev_m  = dev_d[33] ? 32'(-dev_d) : dev_d[31:0];
	assign diff_d = 34'(ma_s) - 34'(mb_s);
	assign diff_m = diff_d[33] ? 33'(-diff_d) : diff_d[32:0];

	assign wsum = (ma_s[32] ? -$signed({1'b0, t_q[43:0]}) : $signed({1'b0, t_q[43:0]}))
	            + (mb_s[32] ? -$signed({1'b0, unit_res[43:0]})
	                        : $signed({1'b0, unit_res[43:0]}));

	assign dev_add  = {1'b0, dev_q} + {17'd0, unit_res[63:16]};
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:     if (sample_valid) state_nxt = awaiting_q ? ST_CM_A : ST_DEV;
			ST_CM_A:     if (unit_done) state_nxt = ST_CM_B;
			ST_CM_B:     if (unit_done) state_nxt = (n == '0) ? ST_DEV : ST_CM_DIV;
			ST_CM_DIV:   if (unit_done) state_nxt = ST_DEV;
			ST_DEV: begin
				if (unit_done) begin
					if (!item_q.is_last) state_nxt = ST_IDLE;
					else state_nxt = degen_cnt ? ST_OUT : ST_POP_DIV;
				end
			end
			ST_POP_DIV:  if (unit_done) state_nxt = ST_POP_SQRT;
			ST_POP_SQRT: if (unit_done) state_nxt = ST_SA;
			ST_SA:       if (unit_done) state_nxt = ST_DA;
			ST_DA:       if (unit_done) state_nxt = ST_SB;
			ST_SB:       if (unit_done) state_nxt = ST_DB;
			ST_DB:       if (unit_done) state_nxt = ST_SP;
			ST_SP:       if (unit_done) state_nxt = ST_VN;
			ST_VN:       if (unit_done) state_nxt = ST_NN;
			ST_NN:       if (unit_done) state_nxt = ST_VD;
			ST_VD:       if (unit_done) state_nxt = ST_TROOT;
			ST_TROOT: begin
				if (unit_done) begin
					state_nxt = (unit_res == 64'd0 || pop_q == 32'd0) ? ST_OUT : ST_EFF;
				end
			end
			ST_EFF:      if (unit_done) state_nxt = ST_TS;
			ST_TS:       if (unit_done) state_nxt = ST_OUT;
			ST_OUT:      if (out_free) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_req  = '0;
		div_req  = '0;
		sqrt_req = '0;
		sample_stall = state_q != ST_IDLE;
		case (state_q)
			ST_CM_A: begin
				mul_req.a = {32'd0, ma_m};
				mul_req.b = {53'd0, na};
			end
			ST_CM_B: begin
				mul_req.a = {32'd0, mb_m};
				mul_req.b = {53'd0, nb};
			end
			ST_CM_DIV: begin
				div_req.a = t_q;
				div_req.b = {52'd0, n};
			end
			ST_DEV: begin
				mul_req.a = {32'd0, dev_m};
				mul_req.b = {32'd0, dev_m};
			end
			ST_POP_DIV: begin
				div_req.a = dev_q;
				div_req.b = {52'd0, n};
			end
			ST_POP_SQRT: sqrt_req.a = capsh(t_q);
			ST_SA: begin
				mul_req.a = {33'd0, item_q.stdev_a};
				mul_req.b = {33'd0, item_q.stdev_a};
			end
			ST_DA: begin
				mul_req.a = t_q;
				mul_req.b = {53'd0, na - CNT_W'(1)};
			end
			ST_SB: begin
				mul_req.a = {33'd0, item_q.stdev_b};
				mul_req.b = {33'd0, item_q.stdev_b};
			end
			ST_DB: begin
				mul_req.a = t_q;
				mul_req.b = {53'd0, nb - CNT_W'(1)};
			end
			ST_SP: begin
				div_req.a = u_q;
				div_req.b = {52'd0, n - (CNT_W+1)'(2)};
			end
			ST_VN: begin
				mul_req.a = t_q;
				mul_req.b = {52'd0, n};
			end
			ST_NN: begin
				mul_req.a = {53'd0, na};
				mul_req.b = {53'd0, nb};
			end
			ST_VD: begin
				div_req.a = u_q;
				div_req.b = t_q;
			end
			ST_TROOT: sqrt_req.a = capsh(t_q);
			ST_EFF: begin
				div_req.a = {15'd0, diff_m, 16'd0};
				div_req.b = {32'd0, pop_q};
			end
			ST_TS: begin
				div_req.a = {15'd0, diff_m, 16'd0};
				div_req.b = t_q;
			end
			default: ;
		endcase
		// Launch once per compute state.
		mul_req.start  = !launched_q && (state_q == ST_CM_A || state_q == ST_CM_B ||
		                 state_q == ST_DEV || state_q == ST_SA || state_q == ST_DA ||
		                 state_q == ST_SB || state_q == ST_DB || state_q == ST_VN ||
		                 state_q == ST_NN);
		div_req.start  = !launched_q && (state_q == ST_CM_DIV || state_q == ST_POP_DIV ||
		                 state_q == ST_SP || state_q == ST_VD || state_q == ST_EFF ||
		                 state_q == ST_TS);
		sqrt_req.start = !launched_q && (state_q == ST_POP_SQRT || state_q == ST_TROOT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			launched_q     <= 1'b0;
			awaiting_q     <= 1'b1;
			dev_q          <= 64'd0;
			cm_q           <= 33'sd0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_nxt != state_q) begin
				launched_q <= 1'b0;
			end else if (mul_req.start || div_req.start || sqrt_req.start) begin
				launched_q <= 1'b1;
			end
			if (state_q == ST_IDLE && sample_valid) begin
				awaiting_q <= 1'b0;
			end
			if (state_q == ST_CM_B && unit_done && n == '0) begin
				cm_q <= 33'sd0;
			end
			if (state_q == ST_CM_DIV && unit_done) begin
				cm_q <= sgn_q ? 33'(-unit_res[32:0]) : unit_res[32:0];
			end
			if (state_q == ST_DEV && unit_done) begin
				dev_q <= dev_add[64] ? '1 : dev_add[63:0];
			end
			// Release the result and start a fresh comparison.
			if (state_q == ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
				awaiting_q     <= 1'b1;
				dev_q          <= 64'd0;
				cm_q           <= 33'sd0;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample_valid) begin
			item_q <= sample;
		end
		if (unit_done) begin
			case (state_q)
				ST_CM_A: t_q <= unit_res;
				ST_CM_B: begin
					sgn_q <= wsum < 0;
					t_q   <= {20'd0, 44'(wsum < 0 ? -wsum : wsum)};
				end
				ST_DEV: begin
					eff_q   <= 32'd0;
					ts_q    <= 32'd0;
					degen_q <= degen_cnt;
				end
				ST_POP_DIV:  t_q <= unit_res;
				ST_POP_SQRT: pop_q <= unit_res[31:0];
				ST_SA:       t_q <= {16'd0, unit_res[63:16]};
				ST_DA:       u_q <= unit_res;
				ST_SB:       t_q <= {16'd0, unit_res[63:16]};
				ST_DB:       u_q <= u_q + unit_res;
				ST_SP:       t_q <= (unit_res > {16'd0, VAR_CAP}) ? {16'd0, VAR_CAP} : unit_res;
				ST_VN:       u_q <= unit_res;
				ST_NN:       t_q <= unit_res;
				ST_VD:       t_q <= unit_res;
				ST_TROOT: begin
					t_q <= unit_res;
					if (unit_res == 64'd0 || pop_q == 32'd0) begin
						degen_q <= 1'b1;
					end
				end
				ST_EFF:      eff_q <= sat(diff_d[33], unit_res);
				ST_TS:       ts_q <= sat(diff_d[33], unit_res);
				default: ;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			result_q.effect_size <= eff_q;
			result_q.t_score     <= ts_q;
			result_q.degenerate  <= degen_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`TGES_ASSERT_NOW(a_result_from_out, $rose(result_valid), $past(state_q == ST_OUT),
		"result appeared without passing the output state")
	`TGES_ASSERT_NOW(a_degen_zero, result_valid && result.degenerate,
		result.effect_size == 32'sd0 && result.t_score == 32'sd0,
		"degenerate result carries nonzero values")
	`TGES_ASSERT_NEXT(a_accept_busy, sample_valid && !sample_stall, state_q != ST_IDLE,
		"accepted transaction did not start work")

endmodule
